// ===== rtl/spl_pkg.sv =====
// Package for the sorted posting list: item structs, entry layout, status and op codes.
// No dependencies; used by spl_entry_ram and sorted_posting_list.
package spl_pkg;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_SKIP    = 2'd1;
  localparam logic [1:0] OP_NEXT    = 2'd2;
  localparam logic [1:0] OP_CURRENT = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NEW    = 3'd1;
  localparam logic [2:0] ST_NOMORE = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_BADLEN = 3'd4;

  localparam logic [3:0] PAYLOAD_BYTES_RESET = 4'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [30:0] key;
    logic [63:0] payload;
    logic [3:0]  payload_len;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] position;
    logic [30:0] entry_id;
    logic [15:0] hit_count;
    logic [63:0] payload_out;
    logic [3:0]  payload_len_out;
    logic [10:0] entry_count;
    logic [30:0] largest_id;
  } out_t;

  typedef struct packed {
    logic [30:0] id;
    logic [15:0] count;
    logic [3:0]  len;
    logic [63:0] payload;
  } entry_t;

endpackage

// ===== rtl/spl_entry_ram.sv =====
// Entry memory of the posting list: one write port, one read port, registered read data.
// Depends on spl_pkg for the entry layout.
module spl_entry_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  spl_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output spl_pkg::entry_t rdata
);

  spl_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sorted_posting_list.sv =====
// Sorted posting list with read cursor: sequencer over one entry memory.
// Depends on spl_pkg and spl_entry_ram.
//
//   channel  handshake            payload
//   input    start, busy          in_item  (spl_pkg::in_t)
//   result   out_valid (strobe)   out_item (spl_pkg::out_t)
//   config   cfg_valid, cfg_ready cfg_data (payload_bytes)
//
// One item at a time. Insert binary-searches, then for a new key shifts the entries at
// and above the insertion point (fill - position of them) up one slot and writes the
// entry; skip-to checks the cursor entry and the next one, then searches. Next and
// current check the cursor. The result strobe lasts one cycle and cannot be held off.
// Reset is synchronous, active low; memory is not cleared, entries read only below fill.
module sorted_posting_list #(
  parameter int CAPACITY          = 1024,
  parameter int PAYLOAD_MAX_BYTES = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  spl_pkg::in_t   in_item,
  output logic           out_valid,
  output spl_pkg::out_t  out_item,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [3:0]     cfg_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE, S_CUR_CHK, S_CUR_EMIT, S_SK0, S_SK0_CMP, S_SK1, S_SK1_CMP,
    S_SR_ISSUE, S_SR_CMP, S_SHIFT, S_PUT
  } state_t;

  state_t          state_r;
  spl_pkg::in_t    item_r;
  logic [3:0]      pbytes_r;
  logic [CW-1:0]   fill_r;
  logic [CW-1:0]   cursor_r;
  logic [30:0]     maxid_r;
  logic [CW-1:0]   lo_r, hi_r, mid_r, where_r, shsrc_r;
  logic            found_r;
  spl_pkg::entry_t ent_r;
  logic            pend_r;
  logic [AW-1:0]   pend_addr_r;
  logic            out_valid_r;
  spl_pkg::out_t   out_r;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  spl_pkg::entry_t wdata, rd_data, new_ent;
  logic [CW-1:0]   mid;
  logic [CW:0]     cur_p1;
  logic [3:0]      limit;
  logic [63:0]     mask;
  logic [CW-1:0]   cur_step;
  logic            key_hit;

  spl_entry_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    mid    = lo_r + ((hi_r - lo_r) >> 1);
    cur_p1 = {1'b0, cursor_r} + 1'b1;
    limit  = (pbytes_r < 4'(PAYLOAD_MAX_BYTES)) ? pbytes_r : 4'(PAYLOAD_MAX_BYTES);
    if (item_r.payload_len >= 4'd8) begin
      mask = '1;
    end else begin
      mask = (64'd1 << {item_r.payload_len, 3'b000}) - 64'd1;
    end
    new_ent.id      = item_r.key;
    new_ent.count   = found_r ? ent_r.count + 16'd1 : 16'd1;
    new_ent.len     = item_r.payload_len;
    new_ent.payload = item_r.payload & mask;
    cur_step = (cursor_r < CW'(CAPACITY)) ? cursor_r + 1'b1 : cursor_r;
    key_hit  = (item_r.key == 31'd0) || (rd_data.id == item_r.key);
  end

  always_comb begin
    case (state_r)
      S_CUR_CHK, S_SK0: raddr = cursor_r[AW-1:0];
      S_SK1:            raddr = cur_p1[AW-1:0];
      S_SR_ISSUE:       raddr = mid[AW-1:0];
      S_SHIFT:          raddr = AW'(shsrc_r - 1'b1);
      default:          raddr = cursor_r[AW-1:0];
    endcase
    // A pending shift write always wins; the final entry write waits for it.
    we    = pend_r || (state_r == S_PUT);
    waddr = pend_r ? pend_addr_r : where_r[AW-1:0];
    wdata = pend_r ? rd_data : new_ent;
  end

  always_ff @(posedge clk) begin : seq_p
    logic          out_valid_nxt;
    logic          pend_nxt;
    spl_pkg::out_t out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pbytes_r    <= spl_pkg::PAYLOAD_BYTES_RESET;
      fill_r      <= '0;
      cursor_r    <= '0;
      maxid_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      out_valid_nxt = 1'b0;
      pend_nxt      = 1'b0;
      out_nxt       = out_r;
      if (cfg_valid) begin
        pbytes_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r <= in_item;
            case (in_item.op)
              spl_pkg::OP_INSERT: begin
                if (in_item.payload_len > limit) begin
                  out_valid_nxt       = 1'b1;
                  out_nxt             = '0;
                  out_nxt.status      = spl_pkg::ST_BADLEN;
                  out_nxt.entry_count = 11'(fill_r);
                  out_nxt.largest_id  = maxid_r;
                end else begin
                  lo_r    <= '0;
                  hi_r    <= fill_r;
                  state_r <= S_SR_ISSUE;
                end
              end
              spl_pkg::OP_SKIP: state_r <= S_SK0;
              spl_pkg::OP_NEXT: begin
                cursor_r <= cur_step;
                state_r  <= S_CUR_CHK;
              end
              default: state_r <= S_CUR_CHK;
            endcase
          end
        end
        S_CUR_CHK, S_SK0: begin
          if (cursor_r < fill_r) begin
            state_r <= (state_r == S_SK0) ? S_SK0_CMP : S_CUR_EMIT;
          end else if (state_r == S_SK0) begin
            state_r <= S_SK1;
          end else begin
            out_valid_nxt       = 1'b1;
            out_nxt             = '0;
            out_nxt.status      = spl_pkg::ST_NOMORE;
            out_nxt.position    = 11'(cursor_r);
            out_nxt.entry_count = 11'(fill_r);
            out_nxt.largest_id  = maxid_r;
            state_r             <= S_IDLE;
          end
        end
        S_CUR_EMIT, S_SK0_CMP, S_SK1_CMP: begin
          if (state_r == S_CUR_EMIT || key_hit) begin
            out_valid_nxt           = 1'b1;
            out_nxt.status          = spl_pkg::ST_OK;
            out_nxt.position        = (state_r == S_SK1_CMP) ? 11'(cur_p1) : 11'(cursor_r);
            out_nxt.entry_id        = rd_data.id;
            out_nxt.hit_count       = rd_data.count;
            out_nxt.payload_out     = rd_data.payload;
            out_nxt.payload_len_out = rd_data.len;
            out_nxt.entry_count     = 11'(fill_r);
            out_nxt.largest_id      = maxid_r;
            if (state_r == S_SK1_CMP) begin
              cursor_r <= CW'(cur_p1);
            end
            state_r <= S_IDLE;
          end else if (state_r == S_SK0_CMP) begin
            state_r <= S_SK1;
          end else begin
            lo_r    <= '0;
            hi_r    <= fill_r;
            state_r <= S_SR_ISSUE;
          end
        end
        S_SK1: begin
          if (cur_p1 < {1'b0, fill_r}) begin
            state_r <= S_SK1_CMP;
          end else begin
            lo_r    <= '0;
            hi_r    <= fill_r;
            state_r <= S_SR_ISSUE;
          end
        end
        S_SR_ISSUE: begin
          if (lo_r < hi_r) begin
            mid_r   <= mid;
            state_r <= S_SR_CMP;
          end else begin
            // Not found: lo is the insertion point.
            found_r <= 1'b0;
            where_r <= lo_r;
            if (item_r.op == spl_pkg::OP_INSERT) begin
              if (fill_r == CW'(CAPACITY)) begin
                out_valid_nxt       = 1'b1;
                out_nxt             = '0;
                out_nxt.status      = spl_pkg::ST_FULL;
                out_nxt.entry_count = 11'(fill_r);
                out_nxt.largest_id  = maxid_r;
                state_r             <= S_IDLE;
              end else begin
                shsrc_r <= fill_r;
                state_r <= S_SHIFT;
              end
            end else begin
              out_valid_nxt       = 1'b1;
              out_nxt             = '0;
              out_nxt.status      = spl_pkg::ST_NOMORE;
              out_nxt.position    = 11'(cursor_r);
              out_nxt.entry_count = 11'(fill_r);
              out_nxt.largest_id  = maxid_r;
              state_r             <= S_IDLE;
            end
          end
        end
        S_SR_CMP: begin
          if (rd_data.id < item_r.key) begin
            lo_r    <= mid_r + 1'b1;
            state_r <= S_SR_ISSUE;
          end else if (rd_data.id > item_r.key) begin
            hi_r    <= mid_r;
            state_r <= S_SR_ISSUE;
          end else begin
            found_r <= 1'b1;
            where_r <= mid_r;
            ent_r   <= rd_data;
            if (item_r.op == spl_pkg::OP_INSERT) begin
              state_r <= S_PUT;
            end else begin
              cursor_r                <= mid_r;
              out_valid_nxt           = 1'b1;
              out_nxt.status          = spl_pkg::ST_OK;
              out_nxt.position        = 11'(mid_r);
              out_nxt.entry_id        = rd_data.id;
              out_nxt.hit_count       = rd_data.count;
              out_nxt.payload_out     = rd_data.payload;
              out_nxt.payload_len_out = rd_data.len;
              out_nxt.entry_count     = 11'(fill_r);
              out_nxt.largest_id      = maxid_r;
              state_r                 <= S_IDLE;
            end
          end
        end
        S_SHIFT: begin
          // Read entry src-1 now, write it one slot up in the next cycle.
          if (shsrc_r > where_r) begin
            shsrc_r     <= shsrc_r - 1'b1;
            pend_nxt    = 1'b1;
            pend_addr_r <= shsrc_r[AW-1:0];
          end else begin
            state_r <= S_PUT;
          end
        end
        S_PUT: begin
          if (!pend_r) begin
            out_valid_nxt           = 1'b1;
            out_nxt.status          = found_r ? spl_pkg::ST_OK : spl_pkg::ST_NEW;
            out_nxt.position        = 11'(where_r);
            out_nxt.entry_id        = new_ent.id;
            out_nxt.hit_count       = new_ent.count;
            out_nxt.payload_out     = new_ent.payload;
            out_nxt.payload_len_out = new_ent.len;
            out_nxt.entry_count     = found_r ? 11'(fill_r) : 11'(fill_r + 1'b1);
            if (!found_r) begin
              fill_r <= fill_r + 1'b1;
              if (item_r.key > maxid_r) begin
                maxid_r <= item_r.key;
              end
            end
            out_nxt.largest_id = (!found_r && item_r.key > maxid_r) ? item_r.key : maxid_r;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      out_r       <= out_nxt;
    end
  end

endmodule

// ===== test/tb_sorted_posting_list.sv =====
// Testbench for sorted_posting_list: directed and random items, with a scoreboard
// that predicts every result from its own copy of the table. Depends on spl_pkg and sorted_posting_list.
module tb_sorted_posting_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 1024;
  localparam int MAX_BYTES = 8;
  localparam longint CYCLE_LIMIT = 6000000;

  class posting_scoreboard;
    logic [30:0] ids[CAP];
    logic [15:0] counts[CAP];
    logic [3:0]  lens[CAP];
    logic [63:0] payloads[CAP];
    int unsigned fill;
    int unsigned cursor;
    logic [30:0] largest;
    logic [3:0]  max_len_reg;
    spl_pkg::out_t pending[$];
    int          errors;

    function void clear();
      fill = 0;
      cursor = 0;
      largest = '0;
      max_len_reg = spl_pkg::PAYLOAD_BYTES_RESET;
      pending.delete();
      errors = 0;
    endfunction

    function void set_max_len(logic [3:0] v);
      max_len_reg = v;
    endfunction

    function void add_expected(spl_pkg::out_t r);
      pending = {pending, r};
    endfunction

    // Returns the index of the key if present, otherwise the insertion point.
    function int unsigned find_id(logic [30:0] key, output bit found);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = fill;
      found = 0;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (ids[mid] < key) lo = mid + 1;
        else if (ids[mid] > key) hi = mid;
        else begin
          found = 1;
          return mid;
        end
      end
      return lo;
    endfunction

    function bit hits(int unsigned pos, logic [30:0] key);
      if (pos >= fill) return 0;
      return key == 0 || ids[pos] == key;
    endfunction

    function spl_pkg::out_t report(logic [2:0] st, int unsigned pos, bit with_entry);
      spl_pkg::out_t r;
      r = '0;
      r.status = st;
      r.position = pos[10:0];
      if (with_entry && pos < fill) begin
        r.entry_id = ids[pos];
        r.hit_count = counts[pos];
        r.payload_out = payloads[pos];
        r.payload_len_out = lens[pos];
      end
      r.entry_count = fill[10:0];
      r.largest_id = largest;
      return r;
    endfunction

    function void note_item(spl_pkg::in_t it);
      int unsigned lim, where;
      bit found;
      logic [2:0] st;
      logic [63:0] mask;
      lim = (max_len_reg < MAX_BYTES) ? max_len_reg : MAX_BYTES;
      case (it.op)
        spl_pkg::OP_INSERT: begin
          if (it.payload_len > lim) begin
            add_expected(report(spl_pkg::ST_BADLEN, 0, 0));
            return;
          end
          where = find_id(it.key, found);
          st = spl_pkg::ST_OK;
          if (!found) begin
            if (fill >= CAP) begin
              add_expected(report(spl_pkg::ST_FULL, 0, 0));
              return;
            end
            for (int i = fill; i > where; i--) begin
              ids[i] = ids[i-1];
              counts[i] = counts[i-1];
              lens[i] = lens[i-1];
              payloads[i] = payloads[i-1];
            end
            fill++;
            ids[where] = it.key;
            counts[where] = 0;
            if (it.key > largest) largest = it.key;
            st = spl_pkg::ST_NEW;
          end
          mask = (it.payload_len >= 8) ? '1 : ((64'd1 << (8 * it.payload_len)) - 64'd1);
          lens[where] = it.payload_len;
          payloads[where] = it.payload & mask;
          counts[where] = counts[where] + 16'd1;
          add_expected(report(st, where, 1));
        end
        spl_pkg::OP_SKIP: begin
          if (!hits(cursor, it.key)) begin
            if (hits(cursor + 1, it.key)) cursor++;
            else begin
              where = find_id(it.key, found);
              if (!found) begin
                add_expected(report(spl_pkg::ST_NOMORE, cursor, 0));
                return;
              end
              cursor = where;
            end
          end
          add_expected(report(spl_pkg::ST_OK, cursor, 1));
        end
        default: begin
          if (it.op == spl_pkg::OP_NEXT && cursor < CAP) cursor++;
          if (cursor < fill) add_expected(report(spl_pkg::ST_OK, cursor, 1));
          else add_expected(report(spl_pkg::ST_NOMORE, cursor, 0));
        end
      endcase
    endfunction

    function void check_result(spl_pkg::out_t got);
      spl_pkg::out_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
      if (got.position !== exp.position)
        $display("%0t: position expected %0d actual %0d", $time, exp.position, got.position);
      if (got.entry_id !== exp.entry_id)
        $display("%0t: entry_id expected %h actual %h", $time, exp.entry_id, got.entry_id);
      if (got.hit_count !== exp.hit_count)
        $display("%0t: hit_count expected %0d actual %0d", $time, exp.hit_count,
                 got.hit_count);
      if (got.payload_out !== exp.payload_out)
        $display("%0t: payload_out expected %h actual %h", $time, exp.payload_out,
                 got.payload_out);
      if (got.payload_len_out !== exp.payload_len_out)
        $display("%0t: payload_len_out expected %0d actual %0d", $time,
                 exp.payload_len_out, got.payload_len_out);
      if (got.entry_count !== exp.entry_count)
        $display("%0t: entry_count expected %0d actual %0d", $time, exp.entry_count,
                 got.entry_count);
      if (got.largest_id !== exp.largest_id)
        $display("%0t: largest_id expected %h actual %h", $time, exp.largest_id,
                 got.largest_id);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  spl_pkg::in_t  in_item;
  logic          out_valid;
  spl_pkg::out_t out_item;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [3:0]    cfg_data;

  posting_scoreboard table_model;
  int  gap_pct;
  longint cycles;

  sorted_posting_list dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) table_model.check_result(out_item);
  end

  initial begin
    cycles = 0;
    wait (cycles >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(spl_pkg::in_t it);
    while ($urandom_range(99) < gap_pct) @(negedge clk);
    start = 1'b1;
    in_item = it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    table_model.note_item(it);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_op(logic [1:0] op, logic [30:0] key, logic [63:0] pl,
                         logic [3:0] len);
    spl_pkg::in_t it;
    it.op = op;
    it.key = key;
    it.payload = pl;
    it.payload_len = len;
    send_item(it);
  endtask

  // Waits until every predicted result has come back, then lets the block settle.
  task automatic drain();
    while (table_model.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_max_len(logic [3:0] v);
    drain();
    cfg_valid = 1'b1;
    cfg_data = v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    table_model.set_max_len(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic spl_pkg::in_t random_item();
    spl_pkg::in_t it;
    int unsigned r;
    int unsigned lim;
    r = $urandom_range(99);
    it.op = (r < 40) ? spl_pkg::OP_INSERT : (r < 70) ? spl_pkg::OP_SKIP :
            (r < 85) ? spl_pkg::OP_NEXT : spl_pkg::OP_CURRENT;
    r = $urandom_range(15);
    if (r == 0) it.key = '0;
    else if (r == 1) it.key = 31'($urandom);
    else if (r == 2) it.key = 31'h7fffffff;
    else it.key = 31'($urandom_range(1, 400));
    it.payload = {$urandom, $urandom};
    lim = (table_model.max_len_reg < MAX_BYTES) ? table_model.max_len_reg : MAX_BYTES;
    if ($urandom_range(7) == 0) it.payload_len = 4'($urandom_range(15));
    else it.payload_len = 4'($urandom_range(0, lim));
    return it;
  endfunction

  initial begin
    table_model = new();
    table_model.clear();
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    gap_pct = 25;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed items under the reset payload limit.
    send_op(spl_pkg::OP_CURRENT, 31'd5, '0, 4'd0);
    send_op(spl_pkg::OP_SKIP, 31'd0, '0, 4'd0);
    send_op(spl_pkg::OP_INSERT, 31'h7fffffff, '1, 4'd4);
    send_op(spl_pkg::OP_INSERT, 31'd0, 64'h0123456789abcdef, 4'd0);
    send_op(spl_pkg::OP_INSERT, 31'd10, '1, 4'd2);
    send_op(spl_pkg::OP_INSERT, 31'd10, 64'hfedcba9876543210, 4'd3);
    send_op(spl_pkg::OP_INSERT, 31'd20, '1, 4'd5);
    send_op(spl_pkg::OP_INSERT, 31'd20, '1, 4'd15);
    send_op(spl_pkg::OP_SKIP, 31'd0, '0, 4'd0);
    send_op(spl_pkg::OP_SKIP, 31'd10, '0, 4'd0);
    send_op(spl_pkg::OP_SKIP, 31'h7fffffff, '0, 4'd0);
    send_op(spl_pkg::OP_SKIP, 31'd11, '0, 4'd0);
    send_op(spl_pkg::OP_NEXT, '0, '0, 4'd0);
    send_op(spl_pkg::OP_NEXT, '0, '0, 4'd0);
    send_op(spl_pkg::OP_CURRENT, '0, '0, 4'd0);
    send_op(spl_pkg::OP_SKIP, 31'd0, '0, 4'd0);
    send_op(spl_pkg::OP_INSERT, 31'd5, '1, 4'd1);
    send_op(spl_pkg::OP_CURRENT, '0, '0, 4'd0);

    write_max_len(4'd8);
    repeat (80) send_item(random_item());

    gap_pct = 87;
    write_max_len(4'd0);
    repeat (80) send_item(random_item());

    gap_pct = 0;
    write_max_len(4'd15);
    repeat (60) send_item(random_item());
    write_max_len(4'd1);
    repeat (20) send_item(random_item());

    // Fill the table to capacity, then push against the full limit and the cursor end.
    write_max_len(4'd8);
    for (int unsigned k = 0; table_model.fill < CAP; k++)
      send_op(spl_pkg::OP_INSERT, 31'(32'h40000000 + k), {$urandom, $urandom}, 4'd8);
    send_op(spl_pkg::OP_INSERT, 31'h3fffffff, '1, 4'd1);
    send_op(spl_pkg::OP_INSERT, 31'h40000000, '1, 4'd8);
    send_op(spl_pkg::OP_SKIP, 31'h40000003, '0, 4'd0);
    send_op(spl_pkg::OP_SKIP, table_model.ids[CAP-1], '0, 4'd0);
    repeat (4) send_op(spl_pkg::OP_NEXT, '0, '0, 4'd0);
    send_op(spl_pkg::OP_CURRENT, '0, '0, 4'd0);
    send_op(spl_pkg::OP_SKIP, 31'd0, '0, 4'd0);
    send_op(spl_pkg::OP_SKIP, 31'h40000001, '0, 4'd0);

    drain();
    if (table_model.errors == 0 && table_model.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
